// ----- src/jasl_pkg.sv -----
// ----------------------------------------------------------------------------
// jasl_pkg
// Shared widths, constants, joint limits and control types for the joint
// angle smoother and limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package jasl_pkg;

	localparam int ANGLE_W = 15;    // Q12 radians, signed
	localparam int STATE_W = 16;    // EMA and previous-output state
	localparam int DT_W    = 16;    // time step, 2^-16 s
	localparam int ALPHA_W = 17;    // Q1.16 weight, 65536 = 1.0
	localparam int RATE_W  = 16;    // Q12 rad/s
	localparam int STEP_W  = 14;    // max_rate * dt >> 16 stays below 2^14
	localparam int DTC_W   = 14;    // clamped time step

	localparam int CFG_W      = 17;
	localparam int CFG_ADDR_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 1'd1;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd16384;
	localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd7149;
	localparam logic [DT_W-1:0]    DT_MIN      = 16'd66;
	localparam logic [DT_W-1:0]    DT_MAX      = 16'd13107;

	// joint limits, pi scaled to Q12 and rounded
	localparam logic signed [ANGLE_W-1:0] LIM_PI     = 15'sd12868;
	localparam logic signed [ANGLE_W-1:0] LIM_PI_3   = 15'sd4289;
	localparam logic signed [ANGLE_W-1:0] LIM_PI_2   = 15'sd6434;
	localparam logic signed [ANGLE_W-1:0] LIM_5PI_6  = 15'sd10723;
	localparam logic signed [ANGLE_W-1:0] LIM_ZERO   = 15'sd0;

	typedef struct packed {
		logic load;     // stage-1 item moves into the output register
		logic primed;   // filter history is valid
	} jasl_ctl_t;

	// limit table repeats every eight lanes
	function automatic logic signed [ANGLE_W-1:0] lane_lo(input logic [2:0] sel);
		logic signed [ANGLE_W-1:0] v;
		unique case (sel)
			3'd0, 3'd1: v = -LIM_PI_3;
			3'd2, 3'd5: v = -LIM_PI;
			3'd3, 3'd6: v = -LIM_PI_2;
			default:    v = LIM_ZERO;
		endcase
		return v;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] lane_hi(input logic [2:0] sel);
		logic signed [ANGLE_W-1:0] v;
		unique case (sel)
			3'd0, 3'd1: v = LIM_PI_3;
			3'd3, 3'd6: v = LIM_5PI_6;
			default:    v = LIM_PI;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- src/jasl_lane.sv -----
// ----------------------------------------------------------------------------
// jasl_lane
// One joint: EMA update, slew limit against the last output and joint clamp.
// Holds the lane's filter state and its stage-2 output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jasl_lane (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire jasl_pkg::jasl_ctl_t                    ctl,
	input  wire logic signed [jasl_pkg::ANGLE_W-1:0]    angle,
	input  wire logic        [jasl_pkg::ALPHA_W-1:0]    alpha,
	input  wire logic        [jasl_pkg::STEP_W-1:0]     slew_max,
	input  wire logic signed [jasl_pkg::ANGLE_W-1:0]    lim_lo,
	input  wire logic signed [jasl_pkg::ANGLE_W-1:0]    lim_hi,
	output logic signed      [jasl_pkg::ANGLE_W-1:0]    angle_s2
);

	logic signed [jasl_pkg::STATE_W-1:0] ema_q;
	logic signed [jasl_pkg::STATE_W-1:0] prev_q;

	logic signed [16:0] x17;
	logic signed [16:0] d;
	logic signed [34:0] prod;
	logic signed [17:0] ema_fil;
	logic signed [15:0] ema_next;
	logic signed [16:0] diff;
	logic signed [16:0] ms;
	logic signed [16:0] step;
	logic signed [17:0] slew;
	logic signed [16:0] pre;
	logic signed [16:0] lo17;
	logic signed [16:0] hi17;
	logic signed [jasl_pkg::ANGLE_W-1:0] res;

	assign x17  = {{2{angle[14]}}, angle};
	// ema + alpha*(x - ema) >> 16 equals the weighted sum floored
	assign d    = x17 - {ema_q[15], ema_q};
	assign prod = $signed({1'b0, alpha}) * d;

	always_comb begin
		ema_fil  = {{2{ema_q[15]}}, ema_q} + {prod[32], prod[32:16]};
		ema_next = ctl.primed ? ema_fil[15:0] : x17[15:0];
		diff     = {ema_next[15], ema_next} - {prev_q[15], prev_q};
		ms       = {3'b000, slew_max};
		if (diff > ms) begin
			step = ms;
		end else if (diff < -ms) begin
			step = -ms;
		end else begin
			step = diff;
		end
		slew = {{2{prev_q[15]}}, prev_q} + {step[16], step};
		pre  = ctl.primed ? slew[16:0] : x17;
		lo17 = {{2{lim_lo[14]}}, lim_lo};
		hi17 = {{2{lim_hi[14]}}, lim_hi};
		if (pre < lo17) begin
			res = lim_lo;
		end else if (pre > hi17) begin
			res = lim_hi;
		end else begin
			res = pre[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_q  <= '0;
			prev_q <= '0;
		end else if (ctl.load) begin
			ema_q  <= ema_next;
			prev_q <= {res[14], res};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			angle_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ----- src/joint_angle_smoother_limiter.sv -----
// ----------------------------------------------------------------------------
// joint_angle_smoother_limiter
// Smooths LANES joint angles per frame, limits their slew and clamps them to
// fixed joint limits.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one frame per transaction: LANES signed Q12 angles and a
//   time step; m_axis returns the LANES filtered angles of that frame.
//   cfg_we/cfg_addr/cfg_wdata write smoothing_alpha (0) and max_rate (1);
//   write them only while no frame is in flight.
//   Pipeline: a frame passes stage 1, then the stage-2 output register,
//   before m_axis_tvalid. Stage 1 registers the angles and the slew step
//   (max_rate * clamped dt); stage 2 runs the per-lane EMA multiply, slew
//   clamp and joint clamp and updates the lane state. The state feedback sits
//   entirely in stage 2: a frame is taken every cycle unless output stalls.
//   Stall: while m_axis_tready is low the output register holds its frame,
//   stage 1 can still take one more, and s_axis_tready drops only when both
//   are full.
//   Reset: filter state clears, the block is unprimed (the first frame passes
//   through to the joint clamp only) and the registers return to
//   alpha = 16384, max_rate = 7149.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_angle_smoother_limiter #(
	parameter int LANES = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [jasl_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [jasl_pkg::CFG_W-1:0]            cfg_wdata,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// angle_in_0 .. angle_in_(LANES-1) (15 b each), time_step (16 b), zero pad
	input  wire logic [((LANES*15+16+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// angle_out_0 .. angle_out_(LANES-1) (15 b each), zero pad
	output logic [((LANES*15+7)/8)*8-1:0]              m_axis_tdata
);

	localparam int AW    = jasl_pkg::ANGLE_W;
	localparam int OUT_W = ((LANES*15+7)/8)*8;

	logic [jasl_pkg::ALPHA_W-1:0] alpha_q;
	logic [jasl_pkg::RATE_W-1:0]  rate_q;
	logic                         primed_q;

	logic                         valid_s1;
	logic                         valid_s2;
	logic [LANES-1:0][AW-1:0]     angle_s1;
	logic [jasl_pkg::STEP_W-1:0]  step_s1;

	logic                         adv_out;
	logic                         take_in;
	logic [jasl_pkg::DT_W-1:0]    dt_raw;
	logic [jasl_pkg::DTC_W-1:0]   dt_c;
	logic [29:0]                  step_prod;
	logic [jasl_pkg::ALPHA_W-1:0] alpha_sat;
	jasl_pkg::jasl_ctl_t          ctl;
	logic [LANES-1:0][AW-1:0]     out_lane;
	logic [LANES*AW-1:0]          out_flat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= jasl_pkg::ALPHA_RESET;
			rate_q  <= jasl_pkg::RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				jasl_pkg::REG_ALPHA: alpha_q <= cfg_wdata;
				jasl_pkg::REG_RATE:  rate_q  <= cfg_wdata[jasl_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign alpha_sat = (alpha_q > jasl_pkg::ALPHA_ONE) ? jasl_pkg::ALPHA_ONE : alpha_q;

	// handshake: output register frees stage 1, stage 1 frees the input
	assign adv_out       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_out;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// slew step from the clamped time step
	assign dt_raw = s_axis_tdata[LANES*AW +: jasl_pkg::DT_W];
	always_comb begin
		if (dt_raw < jasl_pkg::DT_MIN) begin
			dt_c = jasl_pkg::DTC_W'(jasl_pkg::DT_MIN);
		end else if (dt_raw > jasl_pkg::DT_MAX) begin
			dt_c = jasl_pkg::DTC_W'(jasl_pkg::DT_MAX);
		end else begin
			dt_c = dt_raw[jasl_pkg::DTC_W-1:0];
		end
	end
	assign step_prod = rate_q * dt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_out) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && adv_out) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			angle_s1 <= s_axis_tdata[LANES*AW-1:0];
			step_s1  <= step_prod[29:16];
		end
	end

	assign ctl.load   = valid_s1 && adv_out;
	assign ctl.primed = primed_q;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		jasl_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.angle    (angle_s1[g]),
			.alpha    (alpha_sat),
			.slew_max (step_s1),
			.lim_lo   (jasl_pkg::lane_lo(3'(g))),
			.lim_hi   (jasl_pkg::lane_hi(3'(g))),
			.angle_s2 (out_lane[g])
		);
	end

	assign out_flat      = out_lane;
	assign m_axis_tdata  = OUT_W'(out_flat);
	assign m_axis_tvalid = valid_s2;

endmodule

`default_nettype wire

// ----- src/jasl_chk.sv -----
// ----------------------------------------------------------------------------
// jasl_chk
// Port-level checks on the smoother/limiter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module jasl_chk #(
	parameter int LANES = 8
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [((LANES*15+7)/8)*8-1:0]    m_axis_tdata
);

	logic signed [jasl_pkg::ANGLE_W-1:0] out0;
	assign out0 = m_axis_tdata[jasl_pkg::ANGLE_W-1:0];

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");

	// from an idle output, a result follows its input transaction via stage 1
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a matching input transaction");

	// lane 0 always inside its joint limit
	a_lane0_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out0 >= -jasl_pkg::LIM_PI_3) && (out0 <= jasl_pkg::LIM_PI_3))
		else $error("lane 0 outside its joint limit");

endmodule

bind joint_angle_smoother_limiter jasl_chk #(.LANES(LANES)) u_jasl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- bench/jasl_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jasl_frame_checker
// Watches the configuration port and both stream channels of the joint angle
// smoother and limiter. It predicts each frame's filtered angles from its own
// copy of the lane state and registers, and compares them lane by lane, in
// order, with the frames the block returns.
// ----------------------------------------------------------------------------

module jasl_frame_checker #(
	parameter int LANES = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [jasl_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  wire logic [jasl_pkg::CFG_W-1:0]             cfg_wdata,
	input  wire logic                                   s_axis_tvalid,
	input  wire logic                                   s_axis_tready,
	// angle_in_0 .. angle_in_(LANES-1) (15 b each), time_step (16 b), zero pad
	input  wire logic [((LANES*15+16+7)/8)*8-1:0]       s_axis_tdata,
	input  wire logic                                   m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// angle_out_0 .. angle_out_(LANES-1) (15 b each), zero pad
	input  wire logic [((LANES*15+7)/8)*8-1:0]          m_axis_tdata,
	output int                                          in_flight,
	output int                                          mismatches,
	output int                                          frames_checked
);

	localparam int AW    = jasl_pkg::ANGLE_W;
	localparam int IN_W  = ((LANES*15+16+7)/8)*8;
	localparam int OUT_W = ((LANES*15+7)/8)*8;
	localparam longint UNITY = 65536;

	logic [jasl_pkg::ALPHA_W-1:0] alpha_reg;
	logic [jasl_pkg::RATE_W-1:0]  rate_reg;
	logic signed [15:0]           ema_st  [LANES];
	logic signed [15:0]           prev_st [LANES];
	bit                           primed;

	logic [OUT_W-1:0] expected_frames [$];
	logic [OUT_W-1:0] want;
	int               bad;

	// one frame through EMA, slew limit and joint clamp; updates the lane state
	function automatic logic [OUT_W-1:0] smooth_frame(input logic [IN_W-1:0] frame);
		logic [OUT_W-1:0] res;
		longint dt, alpha, step_max, x, y, prev, lo, hi;
		int ln;
		res = '0;
		dt = longint'(frame[LANES*AW +: jasl_pkg::DT_W]);
		if (dt < jasl_pkg::DT_MIN)
			dt = jasl_pkg::DT_MIN;
		else if (dt > jasl_pkg::DT_MAX)
			dt = jasl_pkg::DT_MAX;
		alpha = (alpha_reg > UNITY) ? UNITY : longint'(alpha_reg);
		step_max = (longint'(rate_reg) * dt) >>> 16;
		for (ln = 0; ln < LANES; ln++) begin
			x = longint'($signed(frame[ln*AW +: AW]));
			y = x;
			if (primed) begin
				prev = prev_st[ln];
				y = (alpha * x + (UNITY - alpha) * longint'(ema_st[ln])) >>> 16;
				ema_st[ln] = y[15:0];
				if (y - prev > step_max)
					y = prev + step_max;
				else if (y - prev < -step_max)
					y = prev - step_max;
			end else begin
				ema_st[ln] = x[15:0];
			end
			case (ln % 8)
				0, 1: begin
					lo = -4289;
					hi = 4289;
				end
				2, 5: begin
					lo = -12868;
					hi = 12868;
				end
				3, 6: begin
					lo = -6434;
					hi = 10723;
				end
				default: begin
					lo = 0;
					hi = 12868;
				end
			endcase
			if (y < lo)
				y = lo;
			else if (y > hi)
				y = hi;
			prev_st[ln] = y[15:0];
			res[ln*AW +: AW] = y[AW-1:0];
		end
		primed = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_reg = jasl_pkg::ALPHA_RESET;
			rate_reg  = jasl_pkg::RATE_RESET;
			for (int ln = 0; ln < LANES; ln++) begin
				ema_st[ln]  = '0;
				prev_st[ln] = '0;
			end
			primed = 1'b0;
			expected_frames.delete();
			in_flight      <= 0;
			mismatches     <= 0;
			frames_checked <= 0;
		end else begin
			bad = 0;
			// result side first: a frame cannot come back in the cycle it went in
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_frames.size() == 0) begin
					$error("output transaction with no frame outstanding");
					bad++;
				end else begin
					want = expected_frames.pop_front();
					for (int ln = 0; ln < LANES; ln++) begin
						if (m_axis_tdata[ln*AW +: AW] !== want[ln*AW +: AW]) begin
							$error("angle_out_%0d: expected %0d, got %0d", ln,
								$signed(want[ln*AW +: AW]),
								$signed(m_axis_tdata[ln*AW +: AW]));
							bad++;
						end
					end
					frames_checked <= frames_checked + 1;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_frames.insert(expected_frames.size(), smooth_frame(s_axis_tdata));
			if (cfg_we) begin
				case (cfg_addr)
					jasl_pkg::REG_ALPHA: alpha_reg = cfg_wdata;
					jasl_pkg::REG_RATE:  rate_reg  = cfg_wdata[jasl_pkg::RATE_W-1:0];
					default: ;
				endcase
			end
			mismatches <= mismatches + bad;
			in_flight  <= expected_frames.size();
		end
	end

endmodule

// ----- bench/tb_joint_angle_smoother_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_angle_smoother_limiter
// Drives frames of joint angles and time steps into the smoother and limiter
// under random stalls on both sides, and steps the alpha and rate registers
// through several settings between phases. A directed opening covers the
// unprimed first frame, field extremes and time step clamping; the rest is
// random joint motion mixed with full-range noise.
// ----------------------------------------------------------------------------

module tb_joint_angle_smoother_limiter;

	localparam int LANES = 8;
	localparam int AW    = jasl_pkg::ANGLE_W;
	localparam int IN_W  = ((LANES*15+16+7)/8)*8;
	localparam int OUT_W = ((LANES*15+7)/8)*8;

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               cfg_we        = 1'b0;
	logic [jasl_pkg::CFG_ADDR_W-1:0]    cfg_addr      = '0;
	logic [jasl_pkg::CFG_W-1:0]         cfg_wdata     = '0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [IN_W-1:0]                    s_axis_tdata  = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]                   m_axis_tdata;

	int in_flight, mismatches, frames_checked;
	int idle_pct     = 13;
	int settings_run = 1;
	int traj [LANES];

	initial begin
		forever #2 clk = ~clk;
	end

	joint_angle_smoother_limiter #(.LANES(LANES)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	jasl_frame_checker #(.LANES(LANES)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.in_flight      (in_flight),
		.mismatches     (mismatches),
		.frames_checked (frames_checked)
	);

	// result side back-pressure: random stalls
	always @(posedge clk) begin
		if ($urandom_range(99) < idle_pct) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic push_frame(input logic [IN_W-1:0] frame);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= frame;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// even lanes get a, odd lanes get b
	task automatic push_pair(input int a, input int b, input int dt);
		logic [IN_W-1:0] f;
		f = '0;
		for (int ln = 0; ln < LANES; ln++)
			f[ln*AW +: AW] = (ln % 2 == 0) ? 15'(a) : 15'(b);
		f[LANES*AW +: jasl_pkg::DT_W] = 16'(dt);
		push_frame(f);
	endtask

	// drop valid and wait for every outstanding frame, plus pipeline slack
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input logic [16:0] alpha, input logic [15:0] rate);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= jasl_pkg::REG_ALPHA;
		cfg_wdata <= alpha;
		@(posedge clk);
		cfg_addr  <= jasl_pkg::REG_RATE;
		cfg_wdata <= {1'b0, rate};
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_run++;
	endtask

	// mostly smooth joint motion with the odd jump; the rest is raw noise
	function automatic logic [IN_W-1:0] next_motion_frame();
		logic [IN_W-1:0] f;
		int delta, ln, span;
		f = '0;
		if ($urandom_range(99) < 85) begin
			span = ($urandom_range(9) == 0) ? 6000 : 400;
			for (ln = 0; ln < LANES; ln++) begin
				delta = int'($urandom_range(2 * span)) - span;
				traj[ln] = traj[ln] + delta;
				if (traj[ln] > 12868)
					traj[ln] = 12868;
				else if (traj[ln] < -12868)
					traj[ln] = -12868;
				f[ln*AW +: AW] = 15'(traj[ln]);
			end
			f[LANES*AW +: jasl_pkg::DT_W] = 16'($urandom_range(66, 13107));
		end else begin
			for (ln = 0; ln < LANES; ln++)
				f[ln*AW +: AW] = 15'($urandom);
			f[LANES*AW +: jasl_pkg::DT_W] = 16'($urandom);
		end
		return f;
	endfunction

	initial begin
		int phase, n;
		for (int ln = 0; ln < LANES; ln++)
			traj[ln] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset register values; first frame goes straight to the joint clamp
		push_pair(16383, -16384, 0);
		push_pair(-16384, 16383, 65535);
		push_pair(12868, -12868, 13107);
		push_pair(-12868, 12868, 66);
		push_pair(0, 0, 65);
		push_pair(4289, -4290, 13108);
		push_pair(10723, -6434, 1);
		push_pair(-6435, 10724, 32768);
		push_pair(16383, 16383, 65535);
		push_pair(-16384, -16384, 0);
		settle();

		load_regs(jasl_pkg::ALPHA_ONE, 16'hFFFF);
		push_pair(12868, 12868, 13107);
		push_pair(-12868, -12868, 13107);
		push_pair(0, 0, 66);
		push_pair(16383, -16384, 30000);
		settle();

		// alpha zero and rate zero freeze the outputs
		load_regs(17'd0, 16'd0);
		push_pair(12868, -12868, 13107);
		push_pair(-16384, 16383, 0);
		push_pair(5000, -5000, 4000);
		settle();

		// alpha above one saturates
		load_regs(17'h1FFFF, 16'd1);
		push_pair(12868, -12868, 13107);
		push_pair(-12868, 12868, 13107);
		push_pair(3000, 3000, 65535);
		settle();

		load_regs(17'd1, jasl_pkg::RATE_RESET);
		push_pair(-12868, 12868, 13107);
		push_pair(16383, -16384, 13107);
		push_pair(0, 0, 66);
		settle();

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: load_regs(jasl_pkg::ALPHA_ONE, 16'hFFFF);
				1: load_regs(17'd0, 16'd0);
				2: load_regs(17'($urandom_range(65537, 131071)), 16'($urandom_range(1, 2000)));
				3: load_regs(17'd1, 16'hFFFF);
				5: load_regs(jasl_pkg::ALPHA_RESET, jasl_pkg::RATE_RESET);
				4: load_regs(17'($urandom_range(0, 65536)), 16'($urandom));
				default: load_regs(17'($urandom), 16'($urandom));
			endcase
			idle_pct = (phase == 4) ? 0 : 13;
			for (n = 0; n < 120; n++)
				push_frame(next_motion_frame());
			settle();
		end

		$display("Checked %0d frames across %0d register settings, alpha and rate at",
			frames_checked, settings_run);
		$display("their extremes, with random stalls on both streams.");
		if (mismatches == 0 && in_flight == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
